[rtl/core/sam_pkg.sv]
// Shared constants and types for the suffix automaton matcher.
package sam_pkg;

    localparam int MAX_TEXT  = 1024;
    localparam int ALPHABET  = 26;
    localparam int MAX_NODES = 2 * MAX_TEXT;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LEN_W     = $clog2(MAX_TEXT + 1);
    localparam int SYM_W     = 5;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

    typedef struct packed {
        logic  t_re;
        node_t t_raddr;
        logic  t_we;
        node_t t_waddr;
        row_t  t_wdata;
        logic  i_re;
        node_t i_raddr;
        logic  i_we;
        node_t i_waddr;
        len_t  i_wlen;
        node_t i_wlink;
    } mem_req_t;

    typedef struct packed {
        row_t  t_rdata;
        len_t  i_rlen;
        node_t i_rlink;
    } mem_rsp_t;

endpackage

[rtl/core/sam_if.sv]
// Word channel interfaces for input items and results.
interface sam_in_if;
    logic                     valid;
    logic                     ready;
    logic [sam_pkg::OP_W-1:0] op;
    logic [sam_pkg::SYM_W-1:0] symbol;
    logic                     pattern_end;
    modport source (output valid, op, symbol, pattern_end, input ready);
    modport sink (input valid, op, symbol, pattern_end, output ready);
endinterface

interface sam_out_if;
    logic valid;
    logic ready;
    logic found;
    logic text_overflow;
    modport source (output valid, found, text_overflow, input ready);
    modport sink (input valid, found, text_overflow, output ready);
endinterface

[rtl/core/sam_store.sv]
// Node storage: transition rows and length/link words, registered reads.
module sam_store (
    input  logic              clk,
    input  sam_pkg::mem_req_t req,
    output sam_pkg::mem_rsp_t rsp
);
    import sam_pkg::*;

    row_t                   trans_mem [MAX_NODES];
    logic [LEN_W+NODE_W-1:0] info_mem [MAX_NODES];
    row_t                   t_rdata_reg;
    logic [LEN_W+NODE_W-1:0] i_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.t_we)
        begin
            trans_mem[req.t_waddr] <= req.t_wdata;
        end
        if (req.t_re)
        begin
            t_rdata_reg <= trans_mem[req.t_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.i_we)
        begin
            info_mem[req.i_waddr] <= {req.i_wlen, req.i_wlink};
        end
        if (req.i_re)
        begin
            i_rdata_reg <= info_mem[req.i_raddr];
        end
    end

    assign rsp.t_rdata = t_rdata_reg;
    assign rsp.i_rlen  = i_rdata_reg[LEN_W+NODE_W-1:NODE_W];
    assign rsp.i_rlink = i_rdata_reg[NODE_W-1:0];

endmodule

[rtl/core/sam_ctrl.sv]
// Sequencer: online construction, suffix-link walks, cloning, pattern walk.
module sam_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [sam_pkg::OP_W-1:0]  in_op,
    input  logic [sam_pkg::SYM_W-1:0] in_symbol,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_found,
    output logic                   out_ovf,
    output sam_pkg::mem_req_t      req,
    input  sam_pkg::mem_rsp_t      rsp
);
    import sam_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_Q     = 3'd3;
    localparam logic [2:0] S_LINKQ = 3'd4;
    localparam logic [2:0] S_LINKC = 3'd5;
    localparam logic [2:0] S_CLONE = 3'd6;
    localparam logic [2:0] S_PAT   = 3'd7;

    logic [2:0] state_reg, state_next;
    node_t nodes_reg, nodes_next;
    node_t newest_reg, newest_next;
    len_t  tcount_reg, tcount_next;
    node_t wpos_reg, wpos_next;
    logic  wfail_reg, wfail_next;
    logic  ovf_reg, ovf_next;
    node_t p_reg, p_next;
    node_t q_reg, q_next;
    node_t cur_reg, cur_next;
    node_t clone_reg, clone_next;
    len_t  lencur_reg, lencur_next;
    len_t  lenp_reg, lenp_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic  last_reg, last_next;
    logic  first_reg, first_next;
    logic  ov_reg, ov_next;
    logic  found_reg, found_next;
    logic  ovout_reg, ovout_next;

    logic  in_fire;
    node_t entry;
    node_t row_val;
    row_t  mod_row;
    logic  sym_ok;

    assign in_ready  = (state_reg == S_IDLE) && !(ov_reg && !out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_found = found_reg;
    assign out_ovf   = ovout_reg;
    assign sym_ok    = (in_symbol < SYM_W'(ALPHABET));
    assign entry     = rsp.t_rdata[sym_reg];

    always_comb
    begin
        mod_row          = rsp.t_rdata;
        mod_row[sym_reg] = row_val;
    end

    always_comb
    begin
        state_next  = state_reg;
        nodes_next  = nodes_reg;
        newest_next = newest_reg;
        tcount_next = tcount_reg;
        wpos_next   = wpos_reg;
        wfail_next  = wfail_reg;
        ovf_next    = ovf_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        cur_next    = cur_reg;
        clone_next  = clone_reg;
        lencur_next = lencur_reg;
        lenp_next   = lenp_reg;
        sym_next    = sym_reg;
        last_next   = last_reg;
        first_next  = first_reg;
        ov_next     = ov_reg && !out_ready;
        found_next  = found_reg;
        ovout_next  = ovout_reg;
        row_val     = cur_reg;
        req         = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // root row and root info come up defined
                req.t_we    = 1'b1;
                req.t_waddr = '0;
                req.i_we    = 1'b1;
                req.i_waddr = '0;
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sym_next  = in_symbol;
                    last_next = in_last;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            nodes_next  = node_t'(1);
                            newest_next = '0;
                            tcount_next = '0;
                            wpos_next   = '0;
                            wfail_next  = 1'b0;
                            ovf_next    = 1'b0;
                            req.t_we    = 1'b1;
                            req.t_waddr = '0;
                            req.i_we    = 1'b1;
                            req.i_waddr = '0;
                        end
                        OP_TEXT:
                        begin
                            wpos_next  = '0;
                            wfail_next = 1'b0;
                            if (sym_ok)
                            begin
                                if (tcount_reg >= len_t'(MAX_TEXT))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    tcount_next = tcount_reg + len_t'(1);
                                    cur_next    = nodes_reg;
                                    nodes_next  = nodes_reg + node_t'(1);
                                    newest_next = nodes_reg;
                                    p_next      = newest_reg;
                                    first_next  = 1'b1;
                                    req.t_we    = 1'b1;
                                    req.t_waddr = nodes_reg;
                                    req.t_re    = 1'b1;
                                    req.t_raddr = newest_reg;
                                    req.i_re    = 1'b1;
                                    req.i_raddr = newest_reg;
                                    state_next  = S_WALK;
                                end
                            end
                        end
                        OP_PATTERN:
                        begin
                            if (!wfail_reg && sym_ok)
                            begin
                                req.t_re    = 1'b1;
                                req.t_raddr = wpos_reg;
                                state_next  = S_PAT;
                            end
                            else if (in_last)
                            begin
                                ov_next    = 1'b1;
                                found_next = 1'b0;
                                ovout_next = ovf_reg;
                                wpos_next  = '0;
                                wfail_next = 1'b0;
                            end
                            else
                            begin
                                wfail_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PAT:
            begin
                if (last_reg)
                begin
                    ov_next    = 1'b1;
                    found_next = (entry != '0);
                    ovout_next = ovf_reg;
                    wpos_next  = '0;
                    wfail_next = 1'b0;
                end
                else if (entry == '0)
                begin
                    wfail_next = 1'b1;
                end
                else
                begin
                    wpos_next = entry;
                end
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    // new node length; link fixed up later if not root
                    lencur_next = rsp.i_rlen + len_t'(1);
                    req.i_we    = 1'b1;
                    req.i_waddr = cur_reg;
                    req.i_wlen  = rsp.i_rlen + len_t'(1);
                end
                if (entry == '0)
                begin
                    row_val     = cur_reg;
                    req.t_we    = 1'b1;
                    req.t_waddr = p_reg;
                    req.t_wdata = mod_row;
                    if (p_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next      = rsp.i_rlink;
                        req.t_re    = 1'b1;
                        req.t_raddr = rsp.i_rlink;
                        req.i_re    = 1'b1;
                        req.i_raddr = rsp.i_rlink;
                    end
                end
                else
                begin
                    q_next      = entry;
                    lenp_next   = rsp.i_rlen;
                    req.t_re    = 1'b1;
                    req.t_raddr = entry;
                    req.i_re    = 1'b1;
                    req.i_raddr = entry;
                    state_next  = S_Q;
                end
            end
            S_Q:
            begin
                if (lenp_reg + len_t'(1) == rsp.i_rlen)
                begin
                    req.i_we    = 1'b1;
                    req.i_waddr = cur_reg;
                    req.i_wlen  = lencur_reg;
                    req.i_wlink = q_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // clone copies q's row and link
                    clone_next  = nodes_reg;
                    nodes_next  = nodes_reg + node_t'(1);
                    req.t_we    = 1'b1;
                    req.t_waddr = nodes_reg;
                    req.t_wdata = rsp.t_rdata;
                    req.i_we    = 1'b1;
                    req.i_waddr = nodes_reg;
                    req.i_wlen  = lenp_reg + len_t'(1);
                    req.i_wlink = rsp.i_rlink;
                    state_next  = S_LINKQ;
                end
            end
            S_LINKQ:
            begin
                req.i_we    = 1'b1;
                req.i_waddr = q_reg;
                req.i_wlen  = rsp.i_rlen;
                req.i_wlink = clone_reg;
                state_next  = S_LINKC;
            end
            S_LINKC:
            begin
                req.i_we    = 1'b1;
                req.i_waddr = cur_reg;
                req.i_wlen  = lencur_reg;
                req.i_wlink = clone_reg;
                req.t_re    = 1'b1;
                req.t_raddr = p_reg;
                req.i_re    = 1'b1;
                req.i_raddr = p_reg;
                state_next  = S_CLONE;
            end
            S_CLONE:
            begin
                if (entry == q_reg)
                begin
                    row_val     = clone_reg;
                    req.t_we    = 1'b1;
                    req.t_waddr = p_reg;
                    req.t_wdata = mod_row;
                    if (p_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next      = rsp.i_rlink;
                        req.t_re    = 1'b1;
                        req.t_raddr = rsp.i_rlink;
                        req.i_re    = 1'b1;
                        req.i_raddr = rsp.i_rlink;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            nodes_reg  <= node_t'(1);
            newest_reg <= '0;
            tcount_reg <= '0;
            wpos_reg   <= '0;
            wfail_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            first_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nodes_reg  <= nodes_next;
            newest_reg <= newest_next;
            tcount_reg <= tcount_next;
            wpos_reg   <= wpos_next;
            wfail_reg  <= wfail_next;
            ovf_reg    <= ovf_next;
            first_reg  <= first_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        q_reg      <= q_next;
        cur_reg    <= cur_next;
        clone_reg  <= clone_next;
        lencur_reg <= lencur_next;
        lenp_reg   <= lenp_next;
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        found_reg  <= found_next;
        ovout_reg  <= ovout_next;
    end

endmodule

[rtl/core/suffix_automaton_matcher.sv]
// Text letter: S_WALK walks suffix links, S_Q checks q; a clone adds S_LINKQ and
// S_LINKC; a cloning letter also walks the redirect chain, one node per cycle.
// Pattern letter: S_PAT (skipped when the walk has already failed); result
// registered at the end. Rate is set by the single read port of the row store.
// Reset: async active low; after release S_INIT writes the root, then ready.
// Clear item: restores root-only state.
module suffix_automaton_matcher (
    input logic         clk,
    input logic         rst_n,
    sam_in_if.sink      in_word,
    sam_out_if.source   out_word
);
    import sam_pkg::*;

    mem_req_t req;
    mem_rsp_t rsp;

    // sequencer: owns counters, walk state and result register
    sam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_word.ready),
        .in_op     (in_word.op),
        .in_symbol (in_word.symbol),
        .in_last   (in_word.pattern_end),
        .out_valid (out_word.valid),
        .out_ready (out_word.ready),
        .out_found (out_word.found),
        .out_ovf   (out_word.text_overflow),
        .req       (req),
        .rsp       (rsp)
    );

    // node store: transition rows plus length/link words
    sam_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

endmodule

[rtl/core/sam_checker.sv]
// Port-level checks for the suffix automaton matcher, bound to the top.
module sam_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] op,
    input logic       pattern_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic       found
);
    import sam_pkg::*;

    logic acc_end;
    assign acc_end = in_valid && in_ready && (op == OP_PATTERN) && pattern_end;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found))
        else $error("result word dropped or changed while stalled");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(acc_end, 1) || $past(acc_end, 2))
        else $error("result word without a pattern end");

    a_no_mid: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_PATTERN) && !pattern_end |=> !$rose(out_valid))
        else $error("result word after a mid-pattern letter");

    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result word is blocked");

endmodule

bind suffix_automaton_matcher sam_checker u_sam_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_word.valid),
    .in_ready    (in_word.ready),
    .op          (in_word.op),
    .pattern_end (in_word.pattern_end),
    .out_valid   (out_word.valid),
    .out_ready   (out_word.ready),
    .found       (out_word.found)
);
